// ===== rtl/ssc_pkg.sv =====
// Shared types, constants and opcodes for the SPIR-V spec-constant rewriter.
// It depends on nothing else. The front, queue, back and top files import it.
package ssc_pkg;

   localparam int TARGET_ENTRIES = 64;
   localparam int VALUE_ENTRIES  = 16;
   localparam int HEADER_WORDS   = 5;
   localparam int TGT_IDX_W      = (TARGET_ENTRIES > 1) ? $clog2(TARGET_ENTRIES) : 1;
   localparam int VAL_IDX_W      = (VALUE_ENTRIES > 1) ? $clog2(VALUE_ENTRIES) : 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] OPC_CONST_TRUE  = 16'd41;
   localparam logic [15:0] OPC_CONST_FALSE = 16'd42;
   localparam logic [15:0] OPC_CONST       = 16'd43;
   localparam logic [15:0] OPC_SPEC_TRUE   = 16'd48;
   localparam logic [15:0] OPC_SPEC_FALSE  = 16'd49;
   localparam logic [15:0] OPC_SPEC        = 16'd50;
   localparam logic [15:0] OPC_DECORATE    = 16'd71;
   localparam logic [31:0] DECO_SPEC_ID    = 32'd1;
   localparam logic [15:0] CNT3            = 16'd3;
   localparam logic [15:0] CNT4            = 16'd4;

   localparam logic ITEM_LOAD = 1'b0;
   localparam logic ITEM_WORD = 1'b1;
   localparam logic KIND_BOOL = 1'b0;
   localparam logic KIND_LIT  = 1'b1;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_UNDECO   = 2'd1,
      ERR_TGT_FULL = 2'd2,
      ERR_VAL_FULL = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      MODE_COPY    = 2'd0,
      MODE_REWRITE = 2'd1,
      MODE_DROP    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      FOUND_NONE = 2'd0,
      FOUND_BOOL = 2'd1,
      FOUND_LIT  = 2'd2
   } found_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] spec_id;
      logic        value_kind;
      logic [31:0] spec_value;
      logic [31:0] module_word;
      logic        last_word;
   } item_type;

   typedef struct packed {
      logic [31:0] word;
      logic        valid;
      logic        last;
      err_type     err;
   } result_type;

   typedef struct packed {
      logic [1:0]       count;
      result_type [2:0] res;
   } bundle_type;

endpackage

// ===== rtl/ssc_front.sv =====
// Front end: accepts items, keeps the stream state and both tables, and
// turns each item into a bundle of up to three results. Uses ssc_pkg.
module ssc_front
   import ssc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   input  logic       q_full,
   output logic       push,
   output bundle_type push_bundle
);

   logic [2:0]  header_left_ff, header_left_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] kind_ff, kind_in;
   mode_type    mode_ff, mode_in;
   logic [31:0] held_ff [2];
   logic [31:0] held_in [2];
   found_type   found_kind_ff, found_kind_in;
   logic [31:0] found_value_ff, found_value_in;

   logic [31:0] tgt_keys_ff  [TARGET_ENTRIES];
   logic [31:0] tgt_ids_ff   [TARGET_ENTRIES];
   logic [TARGET_ENTRIES-1:0] tgt_valid_ff;
   logic [31:0] val_ids_ff   [VALUE_ENTRIES];
   logic        val_kinds_ff [VALUE_ENTRIES];
   logic [31:0] val_bits_ff  [VALUE_ENTRIES];
   logic [VALUE_ENTRIES-1:0] val_valid_ff;

   logic                 fire;
   logic [31:0]          w;
   logic [31:0]          tgt_key;
   logic                 tgt_hit, tgt_free;
   logic [TGT_IDX_W-1:0] tgt_hit_idx, tgt_free_idx, tgt_wr_idx;
   logic [31:0]          tgt_sel_id;
   logic [31:0]          val_key;
   logic                 val_hit, val_free;
   logic [VAL_IDX_W-1:0] val_hit_idx, val_free_idx, val_wr_idx;
   logic                 tgt_we, val_we, clear;

   assign fire     = in_valid && !q_full;
   assign in_ready = !q_full;
   assign w        = in_item.module_word;
   assign push     = fire && (push_bundle.count != 2'd0);

   // Target CAM: key is the current word on a lookup, the held target on a store.
   assign tgt_key = (pos_ff == 16'd2) ? w : held_ff[1];

   always_comb begin
      tgt_hit      = 1'b0;
      tgt_free     = 1'b0;
      tgt_hit_idx  = '0;
      tgt_free_idx = '0;
      tgt_sel_id   = '0;
      for (int i = TARGET_ENTRIES - 1; i >= 0; i--) begin
         if (tgt_valid_ff[i] && tgt_keys_ff[i] == tgt_key) begin
            tgt_hit     = 1'b1;
            tgt_hit_idx = TGT_IDX_W'(i);
         end
         if (!tgt_valid_ff[i]) begin
            tgt_free     = 1'b1;
            tgt_free_idx = TGT_IDX_W'(i);
         end
      end
      for (int i = 0; i < TARGET_ENTRIES; i++) begin
         if (tgt_valid_ff[i] && tgt_keys_ff[i] == tgt_key) begin
            tgt_sel_id = tgt_sel_id | tgt_ids_ff[i];
         end
      end
   end
   assign tgt_wr_idx = tgt_hit ? tgt_hit_idx : tgt_free_idx;

   assign val_key = (in_item.opcode == ITEM_LOAD) ? in_item.spec_id : tgt_sel_id;

   always_comb begin
      val_hit      = 1'b0;
      val_free     = 1'b0;
      val_hit_idx  = '0;
      val_free_idx = '0;
      for (int i = VALUE_ENTRIES - 1; i >= 0; i--) begin
         if (val_valid_ff[i] && val_ids_ff[i] == val_key) begin
            val_hit     = 1'b1;
            val_hit_idx = VAL_IDX_W'(i);
         end
         if (!val_valid_ff[i]) begin
            val_free     = 1'b1;
            val_free_idx = VAL_IDX_W'(i);
         end
      end
   end
   assign val_wr_idx = val_hit ? val_hit_idx : val_free_idx;

   always_comb begin
      logic [1:0]  n;
      logic        is_spec;
      logic [15:0] first_op;
      logic [15:0] first_cnt;
      header_left_in = header_left_ff;
      pos_in         = pos_ff;
      len_in         = len_ff;
      kind_in        = kind_ff;
      mode_in        = mode_ff;
      held_in[0]     = held_ff[0];
      held_in[1]     = held_ff[1];
      found_kind_in  = found_kind_ff;
      found_value_in = found_value_ff;
      tgt_we         = 1'b0;
      val_we         = 1'b0;
      clear          = 1'b0;
      push_bundle    = '0;
      n              = 2'd0;
      is_spec        = 1'b0;
      first_op       = OPC_CONST;
      first_cnt      = CNT4;
      if (fire) begin
         if (in_item.opcode == ITEM_LOAD) begin
            if (val_hit || val_free) begin
               val_we = 1'b1;
            end else begin
               push_bundle.res[n] = '{word: 32'd0, valid: 1'b0, last: 1'b0,
                                      err: ERR_VAL_FULL};
               n = n + 2'd1;
            end
         end else begin
            if (header_left_ff != 3'd0) begin
               header_left_in = header_left_ff - 3'd1;
               push_bundle.res[n] = '{word: w, valid: 1'b1, last: 1'b0, err: ERR_NONE};
               n = n + 2'd1;
            end else begin
               if (pos_ff == 16'd0) begin
                  len_in  = (w[31:16] == 16'd0) ? 16'd1 : w[31:16];
                  kind_in = w[15:0];
                  mode_in = MODE_COPY;
               end
               is_spec = (kind_in == OPC_SPEC) || (kind_in == OPC_SPEC_TRUE) ||
                         (kind_in == OPC_SPEC_FALSE);
               if (pos_ff < 16'd2) begin
                  held_in[pos_ff[0]] = w;
                  if (({1'b0, pos_ff} + 17'd1 >= {1'b0, len_in}) || in_item.last_word) begin
                     if (pos_ff == 16'd1) begin
                        push_bundle.res[n] = '{word: held_ff[0], valid: 1'b1, last: 1'b0,
                                               err: ERR_NONE};
                        n = n + 2'd1;
                     end
                     push_bundle.res[n] = '{word: w, valid: 1'b1, last: 1'b0, err: ERR_NONE};
                     n = n + 2'd1;
                  end
               end else if (pos_ff == 16'd2) begin
                  if (is_spec) begin
                     found_kind_in  = FOUND_NONE;
                     found_value_in = 32'd0;
                     if (tgt_hit && val_hit) begin
                        found_kind_in  = (val_kinds_ff[val_hit_idx] == KIND_LIT) ?
                                         FOUND_LIT : FOUND_BOOL;
                        found_value_in = val_bits_ff[val_hit_idx];
                     end
                     // Pick the plain constant opcode from the value, else from the kind.
                     case (found_kind_in)
                        FOUND_BOOL: begin
                           first_cnt = CNT3;
                           first_op  = found_value_in[0] ? OPC_CONST_TRUE : OPC_CONST_FALSE;
                        end
                        FOUND_LIT: begin
                           first_cnt = CNT4;
                           first_op  = OPC_CONST;
                        end
                        default: begin
                           if (kind_in == OPC_SPEC_FALSE) begin
                              first_cnt = CNT3;
                              first_op  = OPC_CONST_FALSE;
                           end else if (kind_in == OPC_SPEC_TRUE) begin
                              first_cnt = CNT3;
                              first_op  = OPC_CONST_TRUE;
                           end else begin
                              first_cnt = CNT4;
                              first_op  = OPC_CONST;
                           end
                        end
                     endcase
                     mode_in = MODE_REWRITE;
                     push_bundle.res[0] = '{word: {first_cnt, first_op}, valid: 1'b1,
                                            last: 1'b0,
                                            err: tgt_hit ? ERR_NONE : ERR_UNDECO};
                     push_bundle.res[1] = '{word: held_ff[1], valid: 1'b1, last: 1'b0,
                                            err: ERR_NONE};
                     push_bundle.res[2] = '{word: w, valid: 1'b1, last: 1'b0, err: ERR_NONE};
                     n = 2'd3;
                  end else if (kind_in == OPC_DECORATE && w == DECO_SPEC_ID) begin
                     mode_in = MODE_DROP;
                  end else begin
                     mode_in = MODE_COPY;
                     push_bundle.res[0] = '{word: held_ff[0], valid: 1'b1, last: 1'b0,
                                            err: ERR_NONE};
                     push_bundle.res[1] = '{word: held_ff[1], valid: 1'b1, last: 1'b0,
                                            err: ERR_NONE};
                     push_bundle.res[2] = '{word: w, valid: 1'b1, last: 1'b0, err: ERR_NONE};
                     n = 2'd3;
                  end
               end else begin
                  if (mode_ff == MODE_DROP) begin
                     if (pos_ff == 16'd3) begin
                        if (tgt_hit || tgt_free) begin
                           tgt_we = 1'b1;
                        end else begin
                           push_bundle.res[n] = '{word: 32'd0, valid: 1'b0, last: 1'b0,
                                                  err: ERR_TGT_FULL};
                           n = n + 2'd1;
                        end
                     end
                  end else if (mode_ff == MODE_REWRITE && pos_ff == 16'd3 &&
                               found_kind_ff == FOUND_LIT) begin
                     push_bundle.res[n] = '{word: found_value_ff, valid: 1'b1, last: 1'b0,
                                            err: ERR_NONE};
                     n = n + 2'd1;
                  end else begin
                     push_bundle.res[n] = '{word: w, valid: 1'b1, last: 1'b0, err: ERR_NONE};
                     n = n + 2'd1;
                  end
               end
               pos_in = ({1'b0, pos_ff} + 17'd1 >= {1'b0, len_in}) ? 16'd0 :
                        pos_ff + 16'd1;
            end
            if (in_item.last_word) begin
               if (n == 2'd0) begin
                  push_bundle.res[0] = '{word: 32'd0, valid: 1'b0, last: 1'b0,
                                         err: ERR_NONE};
                  n = 2'd1;
               end
               push_bundle.res[2'(n - 2'd1)].last = 1'b1;
               clear = 1'b1;
            end
         end
      end
      push_bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         header_left_ff <= 3'(HEADER_WORDS);
         pos_ff         <= '0;
         len_ff         <= '0;
         kind_ff        <= '0;
         mode_ff        <= MODE_COPY;
         found_kind_ff  <= FOUND_NONE;
         found_value_ff <= '0;
         tgt_valid_ff   <= '0;
         val_valid_ff   <= '0;
      end else begin
         header_left_ff <= header_left_in;
         pos_ff         <= pos_in;
         len_ff         <= len_in;
         kind_ff        <= kind_in;
         mode_ff        <= mode_in;
         found_kind_ff  <= found_kind_in;
         found_value_ff <= found_value_in;
         if (tgt_we) begin
            tgt_valid_ff[tgt_wr_idx] <= 1'b1;
         end
         if (val_we) begin
            val_valid_ff[val_wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff[0] <= held_in[0];
      held_ff[1] <= held_in[1];
      if (tgt_we) begin
         tgt_keys_ff[tgt_wr_idx] <= held_ff[1];
         tgt_ids_ff[tgt_wr_idx]  <= w;
      end
      if (val_we) begin
         val_ids_ff[val_wr_idx]   <= in_item.spec_id;
         val_kinds_ff[val_wr_idx] <= in_item.value_kind;
         val_bits_ff[val_wr_idx]  <= in_item.spec_value;
      end
   end

endmodule

// ===== rtl/ssc_queue.sv =====
// Short bundle queue between the front and back ends.
// Uses ssc_pkg for the bundle type and depth.
module ssc_queue
   import ssc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_bundle,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output bundle_type head
);

   bundle_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_bundle;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue pop while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + (QPTR_W+1)'(1))
      else $error("queue count did not advance on push");

endmodule

// ===== rtl/ssc_back.sv =====
// Back end: unless out_ready stalls, walks the head bundle one result
// per cycle into the output register. Uses ssc_pkg for its types.
module ssc_back
   import ssc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   result_type res_ff, res_in;
   logic       load;

   assign load      = head_valid && (!valid_ff || out_ready);
   assign pop       = load && (idx_ff == head.count - 2'd1);
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      res_in   = res_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         res_in   = head.res[idx_ff];
         idx_in   = pop ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

// ===== rtl/spirv_spec_constant_rewriter.sv =====
// Top level of the SPIR-V specialization-constant rewriter.
// Instantiates ssc_front, ssc_queue and ssc_back; uses ssc_pkg.
//
// Load specialization values first (req_tuser = 0), then stream the module one
// word per transfer (req_tuser = 1, req_tlast on the final word). The front end
// takes one item per cycle unless the queue is full; target and value lookups
// are parallel compares over flip-flop tables (64 targets, 16 values). Each
// item yields zero to three results, queued as one bundle in a four-deep
// queue; the back end hands out one result per cycle unless rsp_tready stalls.
// A spec-constant or copied instruction's third word yields three results, so
// throughput is set by the output port at one result per cycle. Both tables
// and the stream state clear as the last word is accepted.
module spirv_spec_constant_rewriter
   import ssc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] spec_id, [32] value_kind, [64:33] spec_value, [96:65] module_word,
   // [103:97] zero
   input  logic [103:0] req_tdata,
   // [0] opcode
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] out_word
   output logic [31:0]  rsp_tdata,
   // [0] word_valid, [2:1] error_code
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast
);

   item_type   item;
   logic       q_full;
   logic       push;
   bundle_type push_bundle;
   logic       pop;
   logic       head_valid;
   bundle_type head;
   result_type out_res;

   // Unpack the request transfer into item fields.
   assign item.opcode      = req_tuser;
   assign item.spec_id     = req_tdata[31:0];
   assign item.value_kind  = req_tdata[32];
   assign item.spec_value  = req_tdata[64:33];
   assign item.module_word = req_tdata[96:65];
   assign item.last_word   = req_tlast;

   ssc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_item     (item),
      .q_full      (q_full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   ssc_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .full        (q_full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head        (head)
   );

   ssc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_res    (out_res)
   );

   // Pack the result register onto the response channel.
   assign rsp_tdata = out_res.word;
   assign rsp_tuser = {out_res.err, out_res.valid};
   assign rsp_tlast = out_res.last;

endmodule
